// File: sv/rot_qual_pkg.sv
// Package for the rotary encoder and button qualifier.
// Holds the item and result types, event codes, register indexes and the step table.
// No dependencies.
`timescale 1ns / 1ps

package rot_qual_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_LEVEL  = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_MS   = 2'd1;
  localparam logic [1:0] CFG_LONG_PRESS_MS = 2'd2;

  // Microseconds as held by the precomputed thresholds (65535 ms fits in 26 bits)
  localparam int unsigned US_BITS = 26;

  // Reset values of the registers
  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd5;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;

  // Input edge source
  typedef enum logic {
    OP_ENCODER = 1'b0,
    OP_SWITCH  = 1'b1
  } op_e;

  // Result event codes
  typedef enum logic [2:0] {
    EV_CW       = 3'd0,
    EV_CCW      = 3'd1,
    EV_SHORT    = 3'd2,
    EV_LONG     = 3'd3,
    EV_RELEASED = 3'd4
  } event_e;

  // Step direction from the quadrature transition table
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_e;

  // One input edge as held in the input register
  typedef struct packed {
    op_e         op;
    logic [63:0] time_us;
    logic        level_a;
    logic        level_b;
    logic        level_switch;
  } item_t;

  // One result beat
  typedef struct packed {
    event_e code;
    logic   pressed_now;
    logic   last_of_run;
  } result_t;

  // Results produced by one item, handed to the output queue
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Quadrature transition table, indexed by previous and current A/B levels.
  function automatic dir_e step_dir(input logic [1:0] prev_ab, input logic [1:0] cur_ab);
    dir_e d;
    unique case ({prev_ab, cur_ab})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: d = DIR_CW;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_CCW;
      default:                            d = DIR_NONE;
    endcase
    return d;
  endfunction

  // Milliseconds to microseconds: v*1000 = v*1024 - v*16 - v*8.
  function automatic logic [US_BITS-1:0] ms_to_us(input logic [15:0] ms);
    logic [US_BITS-1:0] w;
    w = {{(US_BITS-16){1'b0}}, ms};
    return (w << 10) - (w << 4) - (w << 3);
  endfunction

endpackage

// File: sv/rotary_encoder_and_button_qualifier.sv
// Top level of the rotary encoder and button qualifier.
// Depends on rot_qual_pkg, rot_qual_core and rot_qual_fifo.
`timescale 1ns / 1ps

// Takes one time-stamped pin edge per beat and gives encoder step and switch press
// events. An edge beat is registered and decided once the result queue has room,
// one edge per cycle while it has room; an encoder step gives one result beat and
// a switch release gives one or two, so a release takes an extra output beat. The
// four-entry result queue accepts an edge only while it has room for two results.
// Debounce and long-press thresholds are kept in microseconds, computed when the
// registers are written.

module rotary_encoder_and_button_qualifier #(
  parameter int unsigned TIME_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Edge stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // time_us[63:0], level_a, level_b, level_switch, 5'b0
  input  logic        s_axis_tuser,  // operation
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // event_code[2:0], pressed_now, 4'b0
  output logic        m_axis_tlast   // last_of_run
);

  rot_qual_pkg::item_t   item_q;
  logic                  item_valid_q;
  logic                  room;
  logic                  fire;
  rot_qual_pkg::push_t   push;
  rot_qual_pkg::result_t head;

  assign cfg_ready_o   = 1'b1;
  assign fire          = item_valid_q && room;
  assign s_axis_tready = !item_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.op           <= rot_qual_pkg::op_e'(s_axis_tuser);
      item_q.time_us      <= s_axis_tdata[63:0];
      item_q.level_a      <= s_axis_tdata[64];
      item_q.level_b      <= s_axis_tdata[65];
      item_q.level_switch <= s_axis_tdata[66];
    end
  end

  rot_qual_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (item_q),
    .push_o     (push)
  );

  rot_qual_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (head)
  );

  // Output beat packing
  assign m_axis_tdata = {4'b0000, head.pressed_now, head.code};
  assign m_axis_tlast = head.last_of_run;

endmodule

// File: sv/rot_qual_core.sv
// Processing stage: configuration registers, qualifier state and per-item decision logic.
// Depends on rot_qual_pkg.
`timescale 1ns / 1ps

module rot_qual_core #(
  parameter int unsigned TIME_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   fire_i,
  input  rot_qual_pkg::item_t    item_i,
  output rot_qual_pkg::push_t    push_o
);

  localparam int unsigned UB = rot_qual_pkg::US_BITS;

  // Configuration, thresholds kept in microseconds
  logic          active_q;
  logic [UB-1:0] deb_us_q;
  logic [UB-1:0] long_us_q;

  // Qualifier state
  logic [1:0]           prev_ab_q, prev_ab_d;
  logic [TIME_BITS-1:0] acc_time_q, acc_time_d;
  logic                 held_q, held_d;
  logic                 prev_sw_q, prev_sw_d;
  logic [TIME_BITS-1:0] start_q, start_d;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] since;
  logic [TIME_BITS-1:0] dur;
  logic                 bounced;
  logic                 is_long;
  logic                 is_short;
  logic [1:0]           cur_ab;
  rot_qual_pkg::dir_e   dir;

  assign now    = item_i.time_us[TIME_BITS-1:0];
  assign since  = now - acc_time_q;
  assign dur    = now - start_q;
  assign cur_ab = {item_i.level_a, item_i.level_b};
  assign dir    = rot_qual_pkg::step_dir(prev_ab_q, cur_ab);

  assign bounced  = since < {{(TIME_BITS-UB){1'b0}}, deb_us_q};
  // floor(dur/1000) >= n is the same as dur >= n*1000
  assign is_long  = dur >= {{(TIME_BITS-UB){1'b0}}, long_us_q};
  assign is_short = dur >= {{(TIME_BITS-UB){1'b0}}, deb_us_q};

  // Decision for the item in the input register
  always_comb begin
    prev_ab_d  = prev_ab_q;
    acc_time_d = acc_time_q;
    held_d     = held_q;
    prev_sw_d  = prev_sw_q;
    start_d    = start_q;
    push_o     = '0;
    push_o.r0  = '{code: rot_qual_pkg::EV_CW, pressed_now: held_q, last_of_run: 1'b1};
    push_o.r1  = '{code: rot_qual_pkg::EV_RELEASED, pressed_now: 1'b0, last_of_run: 1'b1};
    if (fire_i && !bounced) begin
      if (item_i.op == rot_qual_pkg::OP_ENCODER) begin
        if (dir != rot_qual_pkg::DIR_NONE) begin
          prev_ab_d       = cur_ab;
          acc_time_d      = now;
          push_o.count    = 2'd1;
          push_o.r0.code  = (dir == rot_qual_pkg::DIR_CW) ? rot_qual_pkg::EV_CW
                                                          : rot_qual_pkg::EV_CCW;
        end
      end else if (item_i.level_switch != prev_sw_q) begin
        prev_sw_d  = item_i.level_switch;
        acc_time_d = now;
        if (item_i.level_switch == active_q) begin
          held_d  = 1'b1;
          start_d = now;
        end else begin
          // Release: optional press result, then the released result
          held_d                = 1'b0;
          push_o.r0.pressed_now = 1'b0;
          if (is_long || is_short) begin
            push_o.count          = 2'd2;
            push_o.r0.code        = is_long ? rot_qual_pkg::EV_LONG : rot_qual_pkg::EV_SHORT;
            push_o.r0.last_of_run = 1'b0;
          end else begin
            push_o.count   = 2'd1;
            push_o.r0.code = rot_qual_pkg::EV_RELEASED;
          end
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      deb_us_q  <= rot_qual_pkg::ms_to_us(rot_qual_pkg::DEBOUNCE_MS_RST);
      long_us_q <= rot_qual_pkg::ms_to_us(rot_qual_pkg::LONG_PRESS_MS_RST);
    end else if (cfg_we_i) begin
      if (cfg_index_i == rot_qual_pkg::CFG_ACTIVE_LEVEL) begin
        active_q <= cfg_data_i[0];
      end
      if (cfg_index_i == rot_qual_pkg::CFG_DEBOUNCE_MS) begin
        deb_us_q <= rot_qual_pkg::ms_to_us(cfg_data_i);
      end
      if (cfg_index_i == rot_qual_pkg::CFG_LONG_PRESS_MS) begin
        long_us_q <= rot_qual_pkg::ms_to_us(cfg_data_i);
      end
    end
  end

  // Qualifier state; an active level write reloads the previous switch level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ab_q  <= 2'd0;
      acc_time_q <= '0;
      held_q     <= 1'b0;
      prev_sw_q  <= 1'b1;
      start_q    <= '0;
    end else begin
      prev_ab_q  <= prev_ab_d;
      acc_time_q <= acc_time_d;
      held_q     <= held_d;
      start_q    <= start_d;
      if (cfg_we_i && cfg_index_i == rot_qual_pkg::CFG_ACTIVE_LEVEL) begin
        prev_sw_q <= ~cfg_data_i[0];
      end else begin
        prev_sw_q <= prev_sw_d;
      end
    end
  end

endmodule

// File: sv/rot_qual_fifo.sv
// Result queue: takes up to two results per cycle, gives one beat per cycle when ready.
// Depends on rot_qual_pkg.
`timescale 1ns / 1ps

module rot_qual_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rot_qual_pkg::push_t   push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output rot_qual_pkg::result_t data_o
);

  rot_qual_pkg::result_t mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;
  logic [1:0] wr_ptr_next;

  assign valid_o     = count_q != 3'd0;
  assign data_o      = mem_q[rd_ptr_q];
  assign pop         = valid_o && ready_i;
  // Room for two results, judged on the registered fill level only
  assign room_o      = count_q < 3'd3;
  assign wr_ptr_next = wr_ptr_q + 2'd1;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.count;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + {1'b0, push_i.count} - {2'b00, pop};
    end
  end

endmodule
